// ===== rtl/ipm_pkg.sv =====
// ipm_pkg: shared widths, operation and status codes, controller types
// and the prefix mask helper for the IPv4 prefix match table.
// No dependencies.
package ipm_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int ACT_W       = 8;
  localparam int FUNC_W      = 2;
  localparam int STAT_W      = 2;
  localparam int MAX_LEN     = 32;

  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic issue;
    logic write;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic wr_needed;
  } sts_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== rtl/ipm_req_if.sv =====
// ipm_req_if: request channel, valid/ready with operation payload.
// Depends on ipm_pkg.
interface ipm_req_if;
  logic                          valid;
  logic                          ready;
  logic [ipm_pkg::FUNC_W-1:0]    func;
  logic [ipm_pkg::ADDR_W-1:0]    addr;
  logic [ipm_pkg::LEN_W-1:0]     prefix_len;
  logic [ipm_pkg::ACT_W-1:0]     action_code;

  modport source (output valid, func, addr, prefix_len, action_code, input ready);
  modport sink   (input valid, func, addr, prefix_len, action_code, output ready);
endinterface

// ===== rtl/ipm_rsp_if.sv =====
// ipm_rsp_if: response channel, valid/ready with result payload.
// Depends on ipm_pkg.
interface ipm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ipm_pkg::STAT_W-1:0]    status;
  logic [ipm_pkg::LEN_W-1:0]     match_len;
  logic [ipm_pkg::ACT_W-1:0]     match_action;

  modport source (output valid, status, match_len, match_action, input ready);
  modport sink   (input valid, status, match_len, match_action, output ready);
endinterface

// ===== rtl/ipm_datapath.sv =====
// ipm_datapath: entry memory, scan counter, match trackers and result register.
// Depends on ipm_pkg; driven by ipm_ctrl commands.
module ipm_datapath #(
  parameter int ENTRIES = ipm_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ipm_pkg::cmd_t              cmd,
  output ipm_pkg::sts_t              sts,
  input  logic [ipm_pkg::FUNC_W-1:0] func,
  input  logic [ipm_pkg::ADDR_W-1:0] addr,
  input  logic [ipm_pkg::LEN_W-1:0]  prefix_len,
  input  logic [ipm_pkg::ACT_W-1:0]  action_code,
  output logic [ipm_pkg::STAT_W-1:0] status,
  output logic [ipm_pkg::LEN_W-1:0]  match_len,
  output logic [ipm_pkg::ACT_W-1:0]  match_action
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic                       valid;
    logic [ipm_pkg::LEN_W-1:0]  len;
    logic [ipm_pkg::ACT_W-1:0]  act;
    logic [ipm_pkg::ADDR_W-1:0] pfx;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  entry_t wr_data;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             wr_needed;

  logic [ipm_pkg::FUNC_W-1:0] op_func;
  logic [ipm_pkg::ADDR_W-1:0] op_addr;
  logic [ipm_pkg::ADDR_W-1:0] op_pfx;
  logic [ipm_pkg::LEN_W-1:0]  op_len;
  logic [ipm_pkg::ACT_W-1:0]  op_act;
  logic [ipm_pkg::LEN_W-1:0]  len_sat;

  logic                       hit;
  logic [ipm_pkg::LEN_W-1:0]  best_len;
  logic [ipm_pkg::ACT_W-1:0]  best_act;
  logic                       exact_found;
  logic [IDX_W-1:0]           exact_slot;
  logic                       free_found;
  logic [IDX_W-1:0]           free_slot;

  logic is_exact;
  logic is_cover;

  assign len_sat = (prefix_len > ipm_pkg::LEN_W'(ipm_pkg::MAX_LEN)) ?
                   ipm_pkg::LEN_W'(ipm_pkg::MAX_LEN) : prefix_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_wr || cmd.issue) begin
      idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
    end
  end

  assign sts = '{idx_last: (idx == IDX_LAST), wr_needed: wr_needed};

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func <= func;
      op_addr <= addr;
      op_len  <= len_sat;
      op_pfx  <= addr & ipm_pkg::len_mask(len_sat);
      op_act  <= action_code;
    end
  end

  // memory
  assign wr_en   = cmd.clr_wr || (cmd.write && wr_needed);
  assign wr_addr = cmd.clr_wr ? idx : (exact_found ? exact_slot : free_slot);

  always_comb begin
    wr_data = '0;
    if (!cmd.clr_wr) begin
      wr_data.valid = (op_func == ipm_pkg::FN_ADD);
      wr_data.len   = op_len;
      wr_data.act   = op_act;
      wr_data.pfx   = op_pfx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[idx];
      rd_idx  <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
  end

  // per-entry compare
  assign is_exact = rd_data.valid && (rd_data.len == op_len) && (rd_data.pfx == op_pfx);
  assign is_cover = rd_data.valid &&
                    ((op_addr & ipm_pkg::len_mask(rd_data.len)) == rd_data.pfx);

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      hit         <= 1'b0;
      exact_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (rd_vld) begin
      if (is_cover && (!hit || rd_data.len > best_len)) begin
        hit <= 1'b1;
      end
      if (is_exact && !exact_found) begin
        exact_found <= 1'b1;
      end
      if (!rd_data.valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (is_cover && (!hit || rd_data.len > best_len)) begin
        best_len <= rd_data.len;
        best_act <= rd_data.act;
      end
      if (is_exact && !exact_found) begin
        exact_slot <= rd_idx;
      end
      if (!rd_data.valid && !free_found) begin
        free_slot <= rd_idx;
      end
    end
  end

  always_comb begin
    unique case (op_func)
      ipm_pkg::FN_ADD:    wr_needed = exact_found || free_found;
      ipm_pkg::FN_REMOVE: wr_needed = exact_found;
      default:            wr_needed = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      match_len    <= '0;
      match_action <= '0;
      unique case (op_func)
        ipm_pkg::FN_ADD: begin
          status <= wr_needed ? ipm_pkg::ST_DONE : ipm_pkg::ST_FULL;
        end
        ipm_pkg::FN_LOOKUP: begin
          status <= hit ? ipm_pkg::ST_DONE : ipm_pkg::ST_MISS;
          if (hit) begin
            match_len    <= best_len;
            match_action <= best_act;
          end
        end
        ipm_pkg::FN_REMOVE: begin
          status <= wr_needed ? ipm_pkg::ST_DONE : ipm_pkg::ST_MISS;
        end
        default: begin
          status <= ipm_pkg::ST_MISS;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ipm_ctrl.sv =====
// ipm_ctrl: operation sequencer (clear pass, scan, write-back, result hand-off).
// Depends on ipm_pkg; commands ipm_datapath.
module ipm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ipm_pkg::cmd_t cmd,
  input  ipm_pkg::sts_t sts
);

  ipm_pkg::state_t state;
  ipm_pkg::state_t state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipm_pkg::S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ipm_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.idx_last) begin
          state_next = ipm_pkg::S_IDLE;
        end
      end
      ipm_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ipm_pkg::S_SCAN;
        end
      end
      ipm_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.idx_last) begin
          state_next = ipm_pkg::S_DRAIN;
        end
      end
      ipm_pkg::S_DRAIN: begin
        state_next = ipm_pkg::S_WRITE;
      end
      ipm_pkg::S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ipm_pkg::S_DONE;
      end
      ipm_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ipm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ipm_pkg::S_CLEAR;
      end
    endcase
    rsp_valid_next = cmd.load_result || (rsp_valid && !rsp_ready);
  end

endmodule

// ===== rtl/ip_prefix_match_table.sv =====
// ip_prefix_match_table: IPv4 longest-prefix table, add / lookup / remove.
// Sequence: request taken when idle, scan of every entry, drain, write-back,
// result registered to the response. One transaction at a time: request
// ready is high only in idle; each operation reads every entry once.
// Reset: synchronous; a clearing pass over every entry follows, request
// ready low throughout. Depends on ipm_pkg, ipm_req_if, ipm_rsp_if.
module ip_prefix_match_table #(
  parameter int ENTRIES = ipm_pkg::ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ipm_req_if.sink   req,
  ipm_rsp_if.source rsp
);

  ipm_pkg::cmd_t cmd;
  ipm_pkg::sts_t sts;

  ipm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ipm_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (req.func),
    .addr         (req.addr),
    .prefix_len   (req.prefix_len),
    .action_code  (req.action_code),
    .status       (rsp.status),
    .match_len    (rsp.match_len),
    .match_action (rsp.match_action)
  );

endmodule
